>>> hw/rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg: shared types and constants
// Command codes, status codes, queued command record and back-end states.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int IDX_W         = 10;
  localparam int TABLE_ENTRIES = 1024;
  localparam int FRAME_W       = 20;
  localparam int FLAG_W        = 12;

  localparam logic [FLAG_W-1:0] DIR_FLAGS = 12'h007;

  localparam logic CFG_DIR_READY  = 1'b0;
  localparam logic CFG_TABLE_BASE = 1'b1;

  typedef enum logic [1:0] {
    CMD_MAP    = 2'd0,
    CMD_UNMAP  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_NOT_READY   = 2'd1,
    ST_POOL_EMPTY  = 2'd2,
    ST_NOT_PRESENT = 2'd3
  } status_t;

  typedef struct packed {
    cmd_code_t        op;
    logic [IDX_W-1:0] dir_idx;
    logic [IDX_W-1:0] tbl_idx;
    logic [31:0]      entry;
  } cmd_t;

  typedef struct packed {
    logic               ready;
    logic [FRAME_W-1:0] table_base;
  } cfg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_ZERO,
    S_MAPW,
    S_PT,
    S_FIN
  } state_t;

endpackage

>>> hw/rtl/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine: two-level page table with map/unmap/lookup
// 1024-entry directory plus a pool of second-level tables allocated in order.
//
//   channel | dir | ports
//   in      | in  | in_tvalid in_tready in_tdata in_tuser
//   out     | out | out_tvalid out_tready out_tdata
//   cfg     | in  | cfg_wr_en cfg_index cfg_wdata
//
// Lookup reads the directory, then the pool; map and unmap read only the directory.
// A map that allocates a table adds a sweep that clears all 1024 entries
// of that table, then one entry write.
// After reset the directory is cleared; up to two items queue
// meanwhile.
// A two-deep queue keeps intake going while the walker or the output stalls.
// ----------------------------------------------------------------------------
module two_level_page_table_engine #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // vaddr[31:0], paddr[63:32], page_flags[75:64]
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // phys_frame_addr[31:0], status[33:32], tlb_invalidate[34]
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);

  tlpt_pkg::cfg_t cfg_r;
  logic           q_valid, q_pop;
  tlpt_pkg::cmd_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready      <= 1'b0;
      cfg_r.table_base <= 20'd256;
    end else if (cfg_wr_en) begin
      if (cfg_index == tlpt_pkg::CFG_DIR_READY) cfg_r.ready <= cfg_wdata[0];
      else cfg_r.table_base <= cfg_wdata;
    end
  end

  tlpt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  tlpt_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

>>> hw/rtl/tlpt_front.sv
// ----------------------------------------------------------------------------
// tlpt_front: command intake
// Accepts items, decodes indexes and the new entry, queues them two deep.
// ----------------------------------------------------------------------------
module tlpt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [79:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  output logic          q_valid,
  output tlpt_pkg::cmd_t q_item,
  input  logic          q_pop
);

  tlpt_pkg::cmd_t slot_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  tlpt_pkg::cmd_t dec;
  logic           push;

  always_comb begin
    dec.op      = tlpt_pkg::cmd_code_t'(in_tuser);
    dec.dir_idx = in_tdata[31:22];
    dec.tbl_idx = in_tdata[21:12];
    dec.entry   = {in_tdata[63:44], in_tdata[75:64]};
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push  ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= dec;
    end
  end

endmodule

>>> hw/rtl/tlpt_back.sv
// ----------------------------------------------------------------------------
// tlpt_back: table walker
// Owns directory and table pool memories, runs commands, holds the result.
// ----------------------------------------------------------------------------
module tlpt_back #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tlpt_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  tlpt_pkg::cmd_t q_item,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [39:0]    out_tdata
);

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int IDX_W  = tlpt_pkg::IDX_W;
  localparam int POOL_W = SLOT_W + IDX_W;
  localparam int POOL_D = TABLE_SLOTS * tlpt_pkg::TABLE_ENTRIES;

  logic [31:0] dir_mem  [tlpt_pkg::TABLE_ENTRIES];
  logic [31:0] pool_mem [POOL_D];

  tlpt_pkg::state_t state_r, state_nxt;
  tlpt_pkg::cmd_t   cur_r;
  logic [31:0]      dir_rdata_r, pool_rdata_r;
  logic [IDX_W-1:0] clr_r;
  logic [CNT_W-1:0] nf_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [31:0]      res_frame_r, res_frame_nxt;
  tlpt_pkg::status_t res_st_r, res_st_nxt;
  logic             res_tlb_r, res_tlb_nxt;
  logic             out_valid_r;
  logic [39:0]      out_data_r;

  logic [IDX_W-1:0]  dir_raddr, dir_waddr;
  logic              dir_we;
  logic [31:0]       dir_wdata;
  logic [POOL_W-1:0] pool_raddr, pool_waddr;
  logic              pool_we;
  logic [31:0]       pool_wdata;
  logic              res_load, nf_inc, out_ok;

  logic [19:0]       rel;
  logic              have, pool_full;
  logic [19:0]       new_fr;

  assign rel       = dir_rdata_r[31:12] - cfg.table_base;
  assign have      = dir_rdata_r[0] && (rel < 20'(nf_r));
  assign pool_full = (nf_r >= CNT_W'(TABLE_SLOTS));
  assign new_fr    = cfg.table_base + 20'(nf_r);
  assign out_ok    = !out_valid_r || out_tready;
  assign q_pop     = (state_r == tlpt_pkg::S_IDLE) && q_valid;
  assign dir_raddr = (state_r == tlpt_pkg::S_IDLE) ? q_item.dir_idx : cur_r.dir_idx;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlpt_pkg::S_CLEAR: if (&clr_r) state_nxt = tlpt_pkg::S_IDLE;
      tlpt_pkg::S_IDLE:  if (q_valid) state_nxt = tlpt_pkg::S_DIR;
      tlpt_pkg::S_DIR: begin
        state_nxt = tlpt_pkg::S_FIN;
        if (cfg.ready) begin
          if (cur_r.op == tlpt_pkg::CMD_MAP && !have && !pool_full) begin
            state_nxt = tlpt_pkg::S_ZERO;
          end else if (cur_r.op == tlpt_pkg::CMD_LOOKUP && have) begin
            state_nxt = tlpt_pkg::S_PT;
          end
        end
      end
      tlpt_pkg::S_ZERO:  if (&clr_r) state_nxt = tlpt_pkg::S_MAPW;
      tlpt_pkg::S_MAPW:  state_nxt = tlpt_pkg::S_FIN;
      tlpt_pkg::S_PT:    state_nxt = tlpt_pkg::S_FIN;
      tlpt_pkg::S_FIN:   if (out_ok) state_nxt = tlpt_pkg::S_IDLE;
      default:           state_nxt = tlpt_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    dir_we        = 1'b0;
    dir_waddr     = clr_r;
    dir_wdata     = '0;
    pool_we       = 1'b0;
    pool_waddr    = {slot_r, clr_r};
    pool_wdata    = '0;
    pool_raddr    = {rel[SLOT_W-1:0], cur_r.tbl_idx};
    res_load      = 1'b0;
    res_frame_nxt = '0;
    res_st_nxt    = tlpt_pkg::ST_DONE;
    res_tlb_nxt   = 1'b0;
    slot_nxt      = slot_r;
    nf_inc        = 1'b0;
    unique case (state_r)
      tlpt_pkg::S_CLEAR: dir_we = 1'b1;
      tlpt_pkg::S_DIR: begin
        res_load = 1'b1;
        if (!cfg.ready) begin
          res_st_nxt = tlpt_pkg::ST_NOT_READY;
        end else begin
          case (cur_r.op)
            tlpt_pkg::CMD_MAP: begin
              if (have) begin
                pool_we     = 1'b1;
                pool_waddr  = {rel[SLOT_W-1:0], cur_r.tbl_idx};
                pool_wdata  = cur_r.entry;
                res_tlb_nxt = 1'b1;
              end else if (pool_full) begin
                res_st_nxt = tlpt_pkg::ST_POOL_EMPTY;
              end else begin
                res_load  = 1'b0;
                slot_nxt  = nf_r[SLOT_W-1:0];
                nf_inc    = 1'b1;
                dir_we    = 1'b1;
                dir_waddr = cur_r.dir_idx;
                dir_wdata = {new_fr, tlpt_pkg::DIR_FLAGS};
              end
            end
            tlpt_pkg::CMD_UNMAP: begin
              if (have) begin
                pool_we     = 1'b1;
                pool_waddr  = {rel[SLOT_W-1:0], cur_r.tbl_idx};
                res_tlb_nxt = 1'b1;
              end else begin
                res_st_nxt = tlpt_pkg::ST_NOT_PRESENT;
              end
            end
            tlpt_pkg::CMD_LOOKUP: begin
              if (have) res_load = 1'b0;
              else res_st_nxt = tlpt_pkg::ST_NOT_PRESENT;
            end
            default: ;
          endcase
        end
      end
      tlpt_pkg::S_ZERO: pool_we = 1'b1;
      tlpt_pkg::S_MAPW: begin
        pool_we     = 1'b1;
        pool_waddr  = {slot_r, cur_r.tbl_idx};
        pool_wdata  = cur_r.entry;
        res_load    = 1'b1;
        res_tlb_nxt = 1'b1;
      end
      tlpt_pkg::S_PT: begin
        res_load = 1'b1;
        if (pool_rdata_r[0]) res_frame_nxt = {pool_rdata_r[31:12], 12'h000};
        else res_st_nxt = tlpt_pkg::ST_NOT_PRESENT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpt_pkg::S_CLEAR;
      clr_r       <= '0;
      nf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tlpt_pkg::S_CLEAR || state_r == tlpt_pkg::S_ZERO) begin
        clr_r <= clr_r + 1'b1;
      end
      if (nf_inc) nf_r <= nf_r + 1'b1;
      if (state_r == tlpt_pkg::S_FIN && out_ok) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    slot_r <= slot_nxt;
    if (res_load) begin
      res_frame_r <= res_frame_nxt;
      res_st_r    <= res_st_nxt;
      res_tlb_r   <= res_tlb_nxt;
    end
    if (state_r == tlpt_pkg::S_FIN && out_ok) begin
      out_data_r <= {5'd0, res_tlb_r, res_st_r, res_frame_r};
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    dir_rdata_r <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_waddr] <= pool_wdata;
    pool_rdata_r <= pool_mem[pool_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
